// ===== rtl/stbs_pkg.sv =====
// Shared types for the sorted table binary search block.
// Holds element type, controller state codes and the controller/datapath bundles.
// No dependencies.
package stbs_pkg;

	localparam int unsigned POS_W = 6;

	typedef logic signed [31:0] elem_t;
	typedef logic [POS_W-1:0]   pos_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_RD_I   = 8'b0000_0010,
		ST_CAP_I  = 8'b0000_0100,
		ST_CMP    = 8'b0000_1000,
		ST_WB_I   = 8'b0001_0000,
		ST_PROBE  = 8'b0010_0000,
		ST_CMPS   = 8'b0100_0000,
		ST_RESULT = 8'b1000_0000
	} stbs_state_t;

	typedef struct packed {
		logic load;
		logic search_init;
		logic rd_i;
		logic cap_i;
		logic cmp;
		logic wb_i;
		logic probe;
		logic probe_cmp;
		logic push_out;
	} stbs_cmd_t;

	typedef struct packed {
		logic sort_go;
		logic j_end;
		logic i_end;
		logic empty;
		logic hit;
	} stbs_sts_t;

endpackage

// ===== rtl/stbs_req_if.sv =====
// Request channel: one beat is a load or a search.
// Depends on stbs_pkg.
interface stbs_req_if import stbs_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  mode;
	elem_t value;
	logic  last;

	modport source (output valid, output mode, output value, output last, input ready);
	modport sink (input valid, input mode, input value, input last, output ready);
endinterface

// ===== rtl/stbs_rsp_if.sv =====
// Response channel: one beat per search, found flag and position.
// Depends on stbs_pkg.
interface stbs_rsp_if import stbs_pkg::*; ();
	logic valid;
	logic ready;
	logic found;
	pos_t position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

// ===== rtl/stbs_datapath.sv =====
// Datapath: element memory, load/sort/search counters and the response register.
// Driven by stbs_ctrl through stbs_cmd_t, reports through stbs_sts_t.
// Depends on stbs_pkg.
module stbs_datapath import stbs_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  stbs_cmd_t cmd,
	input  elem_t     value,
	input  logic      last,
	output stbs_sts_t sts,
	output logic      found,
	output pos_t      position
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	elem_t mem [DEPTH];
	elem_t rdata_q;

	logic [CW-1:0] lp_q, cnt_q, lo_q, hp_q;
	logic [AW-1:0] i_q, j_q, mid_q;
	elem_t         cur_q, key_q;
	logic          res_found_q, out_found_q;
	pos_t          res_pos_q, out_pos_q;

	logic          full;
	logic [CW-1:0] lp_nx;
	logic [CW:0]   sum;
	logic [AW-1:0] mid;
	logic [AW+POS_W-1:0] mid_ext;
	logic          swap, gt;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	elem_t         wdata;

	assign full    = lp_q == CW'(DEPTH);
	assign lp_nx   = full ? lp_q : lp_q + CW'(1);
	assign sum     = (CW+1)'(lo_q) + (CW+1)'(hp_q) - (CW+1)'(1);
	assign mid     = sum[AW:1];
	assign mid_ext = {{POS_W{1'b0}}, mid_q};
	assign swap    = cur_q > rdata_q;
	assign gt      = rdata_q > key_q;

	assign sts.sort_go = lp_nx >= CW'(2);
	assign sts.j_end   = CW'(j_q) == cnt_q - CW'(1);
	assign sts.i_end   = CW'(i_q) + CW'(2) == cnt_q;
	assign sts.empty   = lo_q >= hp_q;
	assign sts.hit     = rdata_q == key_q;

	always_comb begin
		we    = 1'b0;
		waddr = lp_q[AW-1:0];
		wdata = value;
		raddr = i_q;
		priority if (cmd.load) begin
			we = !full;
		end else if (cmd.cmp) begin
			we    = swap;
			waddr = j_q;
			wdata = cur_q;
			raddr = j_q + AW'(1);
		end else if (cmd.wb_i) begin
			we    = 1'b1;
			waddr = i_q;
			wdata = cur_q;
		end else if (cmd.cap_i) begin
			raddr = j_q;
		end else if (cmd.probe) begin
			raddr = mid;
		end else begin
			raddr = i_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			if (last) begin
				cnt_q <= lp_nx;
				lp_q  <= '0;
			end else begin
				lp_q <= lp_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && last) begin
			i_q <= '0;
		end
		if (cmd.rd_i) begin
			j_q <= i_q + AW'(1);
		end
		if (cmd.cap_i) begin
			cur_q <= rdata_q;
		end
		if (cmd.cmp) begin
			j_q <= j_q + AW'(1);
			if (swap) begin
				cur_q <= rdata_q;
			end
		end
		if (cmd.wb_i) begin
			i_q <= i_q + AW'(1);
		end
		if (cmd.search_init) begin
			key_q <= value;
			lo_q  <= '0;
			hp_q  <= cnt_q;
		end
		if (cmd.probe) begin
			mid_q       <= mid;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end
		if (cmd.probe_cmp) begin
			priority if (sts.hit) begin
				res_found_q <= 1'b1;
				res_pos_q   <= mid_ext[POS_W-1:0];
			end else if (gt) begin
				hp_q <= CW'(mid_q);
			end else begin
				lo_q <= CW'(mid_q) + CW'(1);
			end
		end
		if (cmd.push_out) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

	assign found    = out_found_q;
	assign position = out_pos_q;

`ifndef SYNTHESIS
	a_lp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= CW'(DEPTH)) else $error("load position past depth");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH)) else $error("table size past depth");
	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe && !sts.empty) |-> (CW'(mid) < hp_q && CW'(mid) >= lo_q))
		else $error("probe outside search range");
`endif

endmodule

// ===== rtl/stbs_ctrl.sv =====
// Controller: sequences loads, the exchange sort and the bisection search.
// Owns request ready and response valid; drives stbs_datapath by stbs_cmd_t.
// Depends on stbs_pkg.
module stbs_ctrl import stbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_mode,
	input  logic      req_last,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  stbs_sts_t sts,
	output stbs_cmd_t cmd
);

	stbs_state_t state_q, state_nx;
	logic        rsp_valid_q;
	logic        accept;

	assign req_ready = state_q == ST_IDLE;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_mode) begin
						cmd.search_init = 1'b1;
						state_nx        = ST_PROBE;
					end else begin
						cmd.load = 1'b1;
						if (req_last && sts.sort_go) begin
							state_nx = ST_RD_I;
						end
					end
				end
			end
			ST_RD_I: begin
				cmd.rd_i = 1'b1;
				state_nx = ST_CAP_I;
			end
			ST_CAP_I: begin
				cmd.cap_i = 1'b1;
				state_nx  = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.j_end) begin
					state_nx = ST_WB_I;
				end
			end
			ST_WB_I: begin
				cmd.wb_i = 1'b1;
				state_nx = sts.i_end ? ST_IDLE : ST_RD_I;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				state_nx  = sts.empty ? ST_RESULT : ST_CMPS;
			end
			ST_CMPS: begin
				cmd.probe_cmp = 1'b1;
				state_nx      = sts.hit ? ST_RESULT : ST_PROBE;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.push_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.push_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_mode) |=> (state_q == ST_PROBE)) else $error("search did not start");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_out |=> (rsp_valid && state_q == ST_IDLE)) else $error("result beat lost");
	a_sort_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && sts.j_end) |=> (state_q == ST_WB_I))
		else $error("inner sort pass did not close");
`endif

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted table binary search block.
// Instantiates stbs_ctrl and stbs_datapath; depends on stbs_pkg, stbs_req_if, stbs_rsp_if.
//
//   channel  dir  beat payload           notes
//   req      in   mode, value, last      mode 0 load, mode 1 search
//   rsp      out  found, position        one beat per search
//
// A load with last mark then sorts the n loaded elements in place with an exchange
// sort, if n is at least 2. Each search step reads the middle element of the
// range, then compares it with the key. Request ready is low while a sort or
// search runs; a waiting response beat does not stop loads. Reset clears the
// load position, table size, controller state and response valid; no memory clearing pass.
module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int unsigned DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	stbs_req_if.sink   req,
	stbs_rsp_if.source rsp
);

	stbs_cmd_t cmd;
	stbs_sts_t sts;

	stbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_last  (req.last),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stbs_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (req.value),
		.last     (req.last),
		.sts      (sts),
		.found    (rsp.found),
		.position (rsp.position)
	);

endmodule

// ===== sim/sorted_table_binary_search_test.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_table_binary_search: directed table then random load/search batches,
// every response beat checked against a local sorted-table predictor or a row's known result.
// Depends on stbs_pkg, stbs_req_if, stbs_rsp_if and the RTL top level.
module sorted_table_binary_search_test;
	import stbs_pkg::*;

	localparam int unsigned DEPTH       = 64;
	localparam int unsigned ITEM_TARGET = 1350;
	localparam logic        MODE_LOAD   = 1'b0;
	localparam logic        MODE_SEARCH = 1'b1;
	localparam elem_t       ELEM_MIN    = 32'sh8000_0000;
	localparam elem_t       ELEM_MAX    = 32'sh7fff_ffff;

	typedef struct {
		logic  mode;
		elem_t value;
		logic  last;
		logic  known;
		logic  found;
		pos_t  position;
	} req_row_t;

	typedef struct {
		logic found;
		pos_t position;
	} lookup_t;

	localparam int unsigned N_DIRECTED = 24;

	req_row_t directed_rows [N_DIRECTED] = '{
		'{MODE_SEARCH, 32'sd5,      1'b0, 1'b1, 1'b0, 6'd0},
		'{MODE_SEARCH, ELEM_MIN,    1'b1, 1'b1, 1'b0, 6'd0},
		'{MODE_LOAD,   ELEM_MAX,    1'b1, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, ELEM_MAX,    1'b0, 1'b1, 1'b1, 6'd0},
		'{MODE_SEARCH, ELEM_MIN,    1'b0, 1'b1, 1'b0, 6'd0},
		'{MODE_LOAD,   ELEM_MIN,    1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   32'sd0,      1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   -32'sd1,     1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   ELEM_MAX,    1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   32'sd7,      1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   32'sd7,      1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   32'sd7,      1'b1, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd7,      1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, ELEM_MIN,    1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, ELEM_MAX,    1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd3,      1'b0, 1'b1, 1'b0, 6'd0},
		'{MODE_SEARCH, -32'sd1,     1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd0,      1'b1, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   32'sd1234,   1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd0,      1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_LOAD,   -32'sd5,     1'b1, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, -32'sd5,     1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd1234,   1'b0, 1'b0, 1'b0, 6'd0},
		'{MODE_SEARCH, 32'sd1233,   1'b0, 1'b1, 1'b0, 6'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	stbs_req_if req ();
	stbs_rsp_if rsp ();

	sorted_table_binary_search #(.DEPTH(DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	elem_t       table_mem [DEPTH];
	int unsigned table_size;
	int unsigned fill_index;
	lookup_t     pending_lookups [$];
	int unsigned mismatch_count;
	req_row_t    cur_row;
	int unsigned burst_left;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void sort_table();
		elem_t swap;
		for (int i = 0; i + 1 < int'(table_size); i++) begin
			for (int j = i + 1; j < int'(table_size); j++) begin
				if (table_mem[i] > table_mem[j]) begin
					swap         = table_mem[i];
					table_mem[i] = table_mem[j];
					table_mem[j] = swap;
				end
			end
		end
	endfunction

	function automatic void apply_load(input elem_t v, input logic closing);
		if (fill_index < DEPTH) begin
			table_mem[fill_index] = v;
			fill_index++;
		end
		if (closing) begin
			table_size = fill_index;
			fill_index = 0;
			sort_table();
		end
	endfunction

	function automatic lookup_t predict_lookup(input elem_t key);
		lookup_t res;
		int      lo;
		int      hi;
		int      mid;
		res.found    = 1'b0;
		res.position = '0;
		lo           = 0;
		hi           = int'(table_size) - 1;
		if (hi > int'(DEPTH) - 1)
			hi = int'(DEPTH) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (table_mem[mid] > key) begin
				hi = mid - 1;
			end else if (table_mem[mid] < key) begin
				lo = mid + 1;
			end else begin
				res.found    = 1'b1;
				res.position = pos_t'(mid);
				break;
			end
		end
		return res;
	endfunction

	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got.found    = rsp.found;
				got.position = rsp.position;
				if (pending_lookups.size() == 0) begin
					report_mismatch($sformatf("response beat with nothing expected (found %0b pos %0d)",
						got.found, got.position));
				end else begin
					want = pending_lookups.pop_front();
					if (got.found !== want.found)
						report_mismatch($sformatf("found %0b, expected %0b",
							got.found, want.found));
					if (got.position !== want.position)
						report_mismatch($sformatf("position %0d, expected %0d",
							got.position, want.position));
				end
			end
			if (req.valid && req.ready) begin
				if (req.mode == MODE_LOAD) begin
					apply_load(req.value, req.last);
				end else begin
					want = predict_lookup(req.value);
					if (cur_row.known) begin
						want.found    = cur_row.found;
						want.position = cur_row.position;
					end
					pending_lookups.push_back(want);
				end
			end
		end
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			int unsigned seg_len;
			int unsigned style;
			seg_len = $urandom_range(1, 40);
			style   = $urandom_range(0, 3);
			repeat (seg_len) begin
				@(posedge clk);
				case (style)
				0, 1: begin
					rsp.ready <= 1'b1;
				end
				2: begin
					rsp.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					rsp.ready <= ($urandom_range(0, 3) == 0);
				end
				endcase
			end
		end
	end

	task automatic send_beat(input req_row_t row);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		end
		req.valid <= 1'b1;
		req.mode  <= row.mode;
		req.value <= row.value;
		req.last  <= row.last;
		cur_row   <= row;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		burst_left--;
	endtask

	function automatic req_row_t make_row(input logic mode, input elem_t v, input logic last);
		req_row_t row;
		row.mode     = mode;
		row.value    = v;
		row.last     = last;
		row.known    = 1'b0;
		row.found    = 1'b0;
		row.position = '0;
		return row;
	endfunction

	function automatic elem_t pick_key(input elem_t batch_vals [$]);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60 && batch_vals.size() != 0)
			return batch_vals[$urandom_range(0, batch_vals.size() - 1)];
		if (roll < 75 && batch_vals.size() != 0)
			return batch_vals[$urandom_range(0, batch_vals.size() - 1)] +
				(($urandom_range(0, 1) == 0) ? -32'sd1 : 32'sd1);
		if (roll < 88) begin
			case ($urandom_range(0, 3))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return 32'sd0;
			default: return -32'sd1;
			endcase
		end
		return elem_t'($urandom());
	endfunction

	task automatic run_random();
		int unsigned sent;
		int unsigned batch_no;
		int unsigned n_loads;
		int unsigned n_searches;
		int unsigned open_fill;
		logic        narrow;
		logic        closing;
		elem_t       base;
		elem_t       v;
		elem_t       batch_vals [$];
		sent      = 0;
		batch_no  = 0;
		open_fill = 0;
		while (sent < ITEM_TARGET) begin
			if (batch_no == 0)
				n_loads = DEPTH;
			else if (batch_no == 1)
				n_loads = DEPTH + 6;
			else if ($urandom_range(0, 11) == 0)
				n_loads = $urandom_range(33, DEPTH + 6);
			else
				n_loads = $urandom_range(1, 16);
			narrow = ($urandom_range(0, 2) == 0);
			base   = elem_t'($urandom());
			batch_vals.delete();
			for (int unsigned k = 0; k < n_loads; k++) begin
				if ($urandom_range(0, 14) == 0) begin
					send_beat(make_row(MODE_SEARCH, pick_key(batch_vals), 1'($urandom_range(0, 1))));
					sent++;
				end
				if (narrow)
					v = base + elem_t'($urandom_range(0, 7));
				else if ($urandom_range(0, 19) == 0)
					v = ($urandom_range(0, 1) == 0) ? ELEM_MIN : ELEM_MAX;
				else
					v = elem_t'($urandom());
				batch_vals.push_back(v);
				closing = (k == n_loads - 1) && (batch_no < 2 || $urandom_range(0, 9) != 0);
				send_beat(make_row(MODE_LOAD, v, closing));
				if (open_fill < DEPTH) begin
					open_fill++;
					sent++;
				end
				if (closing)
					open_fill = 0;
			end
			n_searches = $urandom_range(2, 12);
			repeat (n_searches) begin
				send_beat(make_row(MODE_SEARCH, pick_key(batch_vals), ($urandom_range(0, 19) == 0)));
				sent++;
			end
			batch_no++;
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.mode       <= MODE_LOAD;
		req.value      <= '0;
		req.last       <= 1'b0;
		table_size     = 0;
		fill_index     = 0;
		mismatch_count = 0;
		burst_left     = 0;
		cur_row        = make_row(MODE_LOAD, '0, 1'b0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int unsigned r = 0; r < N_DIRECTED; r++)
			send_beat(directed_rows[r]);
		run_random();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sorted_table_binary_search.f =====
rtl/stbs_pkg.sv
rtl/stbs_req_if.sv
rtl/stbs_rsp_if.sv
rtl/stbs_datapath.sv
rtl/stbs_ctrl.sv
rtl/sorted_table_binary_search.sv
sim/sorted_table_binary_search_test.sv
